FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mbps_pkg.sv
// types, codes and helpers for the masked byte pattern scanner
`default_nettype none

package mbps_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int LEN_W    = 7;
    localparam int RESULT_W = 32;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [RESULT_W-1:0] result_t;

    // pattern entry kinds
    localparam kind_t KIND_EXACT = 2'd0;
    localparam kind_t KIND_ANY   = 2'd1;
    localparam kind_t KIND_NEVER = 2'd2;

    // input word actions
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_DATA = 1'b1;

    // one accepted input word as seen by the state store
    typedef struct packed {
        logic   load;
        logic   shift;
        logic   restart;
        index_t index;
        byte_t  entry_byte;
        kind_t  entry_kind;
        byte_t  data_byte;
    } step_t;

    // compare one pattern entry against one window byte
    function automatic logic entry_hit(kind_t kind, byte_t want, byte_t got);
        logic hit;
        case (kind)
            KIND_EXACT: hit = (want == got);
            KIND_ANY:   hit = 1'b1;
            KIND_NEVER: hit = 1'b0;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mbps_in_if.sv
// input channel: pattern loads and data bytes
`default_nettype none

interface mbps_in_if import mbps_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   action;
    index_t entry_index;
    byte_t  entry_byte;
    kind_t  entry_kind;
    byte_t  data_byte;
    logic   start_of_buffer;

    modport source (
        output valid, action, entry_index, entry_byte, entry_kind, data_byte,
               start_of_buffer,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, entry_byte, entry_kind, data_byte,
               start_of_buffer,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/mbps_out_if.sv
// output channel: match offsets
`default_nettype none

interface mbps_out_if import mbps_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t match_offset;

    modport source (
        output valid, match_offset,
        input  ready
    );

    modport sink (
        input  valid, match_offset,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/masked_byte_pattern_scan.sv
// top level of the masked byte pattern scanner
//
//  channel    direction  word
//  items      sink       pattern entry load or one data byte
//  results    source     match offset within the current buffer
//  cfg        write      pattern length
//
// one word accepted per cycle unless the input is stalled; an accepted data byte updates the window
// and the evaluate register, the compare of that window lands in the result register once the
// output is free, and the result leaves from there
// the compare is one pass of shifter, byte comparators and an and tree
// reset clears window, byte count, pattern length and the handshake state
// input stalls only while a match waits behind an unread result
`default_nettype none
`include "assert_macros.svh"

module masked_byte_pattern_scan import mbps_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int OFFSET_BITS = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  len_t             cfg_wdata,
    mbps_in_if.sink          items,
    mbps_out_if.source       results
);

    len_t                               len_reg;
    step_t                              step;
    logic                               accept;
    logic                               take_ready;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_bytes;
    logic [MAX_PATTERN-1:0][KIND_W-1:0] pattern_kinds;
    logic [OFFSET_BITS-1:0]             bytes_seen;

    // pattern length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    // decode the accepted word
    always_comb
    begin
        accept            = items.valid && take_ready;
        step.load         = accept && (items.action == ACTION_LOAD)
                         && (int'(items.entry_index) < MAX_PATTERN);
        step.shift        = accept && (items.action == ACTION_DATA);
        step.restart      = items.start_of_buffer;
        step.index        = items.entry_index;
        step.entry_byte   = items.entry_byte;
        step.entry_kind   = items.entry_kind;
        step.data_byte    = items.data_byte;
    end

    assign items.ready = take_ready;

    mbps_store #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .window        (window),
        .pattern_bytes (pattern_bytes),
        .pattern_kinds (pattern_kinds),
        .bytes_seen    (bytes_seen)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .eval_start     (step.shift),
        .pattern_length (len_reg),
        .window         (window),
        .pattern_bytes  (pattern_bytes),
        .pattern_kinds  (pattern_kinds),
        .bytes_seen     (bytes_seen),
        .take_ready     (take_ready),
        .results        (results)
    );

    // input stalls only behind a held result
    `ASSERT_IMPLIES(a_stall_only_when_blocked, clk, rst_n, !items.ready,
        results.valid && !results.ready, "input stalled without a blocked result")

    // a fresh result always traces back to an accepted data byte through the evaluate and output-valid registers
    `ASSERT_IMPLIES(a_result_after_data, clk, rst_n, $rose(results.valid),
        $past(step.shift, 2), "result without a preceding data word")

endmodule

`default_nettype wire

FILE: sv/mbps_store.sv
// pattern store, byte window and per-buffer byte count
`default_nettype none

module mbps_store import mbps_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int OFFSET_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  step_t                                 step,
    output logic [MAX_PATTERN-1:0][BYTE_W-1:0]    window,
    output logic [MAX_PATTERN-1:0][BYTE_W-1:0]    pattern_bytes,
    output logic [MAX_PATTERN-1:0][KIND_W-1:0]    pattern_kinds,
    output logic [OFFSET_BITS-1:0]                bytes_seen
);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_byte_reg;
    logic [MAX_PATTERN-1:0][KIND_W-1:0] pat_kind_reg;
    logic [OFFSET_BITS-1:0]             seen_reg;
    logic [OFFSET_BITS-1:0]             seen_next;
    logic [OFFSET_BITS-1:0]             seen_base;

    // window shifts by one byte, newest at position zero
    always_comb
    begin
        window_next[0] = step.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
    end

    // saturating byte count, restarted at start of buffer
    always_comb
    begin
        seen_base = step.restart ? '0 : seen_reg;
        seen_next = (seen_base != '1) ? seen_base + 1'b1 : seen_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else if (step.shift)
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
        end
    end

    // pattern entries, one write decode per entry
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (step.load && (int'(step.index) == k))
            begin
                pat_byte_reg[k] <= step.entry_byte;
                pat_kind_reg[k] <= step.entry_kind;
            end
        end
    end

    assign window        = window_reg;
    assign pattern_bytes = pat_byte_reg;
    assign pattern_kinds = pat_kind_reg;
    assign bytes_seen    = seen_reg;

endmodule

`default_nettype wire

FILE: sv/mbps_match.sv
// window compare against the pattern and the result register
`default_nettype none

module mbps_match import mbps_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int OFFSET_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  logic                                  eval_start,
    input  len_t                                  pattern_length,
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0]    window,
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0]    pattern_bytes,
    input  logic [MAX_PATTERN-1:0][KIND_W-1:0]    pattern_kinds,
    input  logic [OFFSET_BITS-1:0]                bytes_seen,
    output logic                                  take_ready,
    mbps_out_if.source                            results
);

    localparam int SHIFT_W = $clog2(MAX_PATTERN + 1);
    localparam int WIDE_W  = (OFFSET_BITS > RESULT_W) ? OFFSET_BITS : RESULT_W;

    logic                               eval_reg;
    logic                               eval_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    result_t                            offset_reg;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] rev;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned;
    logic [SHIFT_W-1:0]                 shift_amt;
    logic [MAX_PATTERN-1:0]             hit_vec;
    logic                               len_ok;
    logic                               seen_ok;
    logic                               hit;
    logic [OFFSET_BITS-1:0]             diff;
    logic [WIDE_W-1:0]                  diff_wide;
    result_t                            offset;
    logic                               out_free;
    logic                               eval_done;

    // oldest byte first, then drop the bytes older than the pattern
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            rev[k] = window[MAX_PATTERN-1-k];
        end
        shift_amt = SHIFT_W'(MAX_PATTERN) - SHIFT_W'(pattern_length);
        aligned   = rev >> (BYTE_W * int'(shift_amt));
    end

    // per-entry compare, entries past the length always pass
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            hit_vec[i] = (i >= int'(pattern_length))
                      || entry_hit(pattern_kinds[i], pattern_bytes[i], aligned[i]);
        end
    end

    // full match and start offset
    always_comb
    begin
        len_ok    = (pattern_length != '0) && (int'(pattern_length) <= MAX_PATTERN);
        seen_ok   = (bytes_seen >= OFFSET_BITS'(pattern_length));
        hit       = len_ok && seen_ok && (&hit_vec);
        diff      = bytes_seen - OFFSET_BITS'(pattern_length);
        diff_wide = WIDE_W'(diff);
        offset    = diff_wide[RESULT_W-1:0];
    end

    // handshake: evaluation holds only while a hit waits on a full output
    always_comb
    begin
        out_free   = !out_valid_reg || results.ready;
        eval_done  = !eval_reg || !hit || out_free;
        take_ready = eval_done;
        eval_next  = eval_start || (eval_reg && !eval_done);
        if (eval_reg && hit && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eval_reg      <= eval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (eval_reg && hit && out_free)
        begin
            offset_reg <= offset;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.match_offset = offset_reg;

endmodule

`default_nettype wire
